FILE: sv/zorder_bit_interleave_encoder_defines.svh
// assertion macros used by the checker file
`ifndef ZORDER_BIT_INTERLEAVE_ENCODER_DEFINES_SVH
`define ZORDER_BIT_INTERLEAVE_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, switched off during rst
`define ZBIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, switched off during rst
`define ZBIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/zbie_pkg.sv
// shared constants and types of the z-order encoder
package zbie_pkg;

  // code word and register geometry
  localparam int WORD_BITS = 32;
  localparam int DIM_W     = 5;
  localparam int DIM_LIMIT = 31;
  localparam logic [DIM_W-1:0] DIM_RESET = 5'd2;
  localparam logic [DIM_W-1:0] DIM_MIN   = 5'd1;

  // queue between loader and emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_DIM_COUNT = 1'b0;

  typedef logic [DIM_W-1:0] dims_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: sv/zbie_front.sv
// loader: scatters each coordinate into its interleaved bit positions
module zbie_front #(
  parameter int NUM_WORDS  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  input  logic [zbie_pkg::WORD_BITS-1:0]              coordinate,
  input  zbie_pkg::dims_t                             dims,
  input  logic                                        clear,
  output logic                                        push,
  output logic [zbie_pkg::WORD_BITS*NUM_WORDS-1:0]    code
);

  localparam int CODE_W = zbie_pkg::WORD_BITS * NUM_WORDS;
  localparam int EXT_W  = (COORD_BITS > zbie_pkg::WORD_BITS) ? COORD_BITS
                                                             : zbie_pkg::WORD_BITS;

  zbie_pkg::dims_t   count;
  logic [EXT_W-1:0]  coord_ext;
  logic [CODE_W-1:0] spread;
  logic [CODE_W-1:0] shifted;
  logic [CODE_W-1:0] merged;
  logic [CODE_W-1:0] acc;
  logic              last;

  assign coord_ext = EXT_W'(coordinate);

  // bit b of the coordinate goes to stream position b*dims (msb first)
  always_comb begin
    spread = '0;
    for (int dd = 1; dd <= NUM_WORDS; dd++) begin
      if (int'(dims) == dd) begin
        for (int b = 0; b < COORD_BITS; b++) begin
          if (b * dd < CODE_W) begin
            spread[CODE_W-1-b*dd] = coord_ext[COORD_BITS-1-b];
          end
        end
      end
    end
  end

  // offset by the coordinate's place in the vector and merge
  assign shifted = spread >> count;
  assign merged  = ((count == '0) ? '0 : acc) | shifted;
  assign last    = ({1'b0, count} + 1'b1) >= {1'b0, dims};

  assign push = load && last;
  assign code = merged;

  // coordinate counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (load) begin
      count <= last ? '0 : count + 1'b1;
    end
  end

  // partial code of the vector being loaded
  always_ff @(posedge clk) begin
    if (load) begin
      acc <= merged;
    end
  end

endmodule

FILE: sv/zbie_queue.sv
// short queue of finished codes between loader and emitter
module zbie_queue #(
  parameter int WIDTH = 517
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       head,
  output zbie_pkg::fifo_status_t status
);

  logic [WIDTH-1:0]              entries [zbie_pkg::QUEUE_DEPTH];
  logic [zbie_pkg::QPTR_W-1:0]   wr_ptr;
  logic [zbie_pkg::QPTR_W-1:0]   rd_ptr;
  logic [zbie_pkg::QCNT_W-1:0]   fill;
  logic                          do_push;
  logic                          do_pop;

  function automatic logic [zbie_pkg::QPTR_W-1:0] ptr_inc(
    input logic [zbie_pkg::QPTR_W-1:0] p
  );
    if (p == zbie_pkg::QPTR_W'(zbie_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.full  = (fill == zbie_pkg::QCNT_W'(zbie_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: sv/zbie_back.sv
// emitter: sends the words of the head code, one per cycle
module zbie_back #(
  parameter int NUM_WORDS = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic [zbie_pkg::WORD_BITS*NUM_WORDS+zbie_pkg::DIM_W-1:0] head,
  input  zbie_pkg::fifo_status_t                                status,
  output logic                                                  pop,
  output logic                                                  word_valid,
  output logic [zbie_pkg::WORD_BITS-1:0]                        code_word,
  output logic                                                  last_word
);

  localparam int CODE_W = zbie_pkg::WORD_BITS * NUM_WORDS;
  localparam int IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  zbie_pkg::dims_t                head_dims;
  logic [CODE_W-1:0]              head_code;
  logic [zbie_pkg::WORD_BITS-1:0] words [NUM_WORDS];
  logic [IDX_W-1:0]               idx;
  logic                           at_last;

  assign {head_dims, head_code} = head;

  // word view of the head code, first word at the top
  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_words
    assign words[w] = head_code[CODE_W-1-zbie_pkg::WORD_BITS*w -: zbie_pkg::WORD_BITS];
  end

  assign at_last = (zbie_pkg::DIM_W'(idx) + 1'b1) == head_dims;
  assign pop     = !status.empty && at_last;

  // word index and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      word_valid <= 1'b0;
      last_word  <= 1'b0;
    end else begin
      word_valid <= !status.empty;
      last_word  <= !status.empty && at_last;
      if (!status.empty) begin
        idx <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    code_word <= words[idx];
  end

endmodule

FILE: sv/zorder_bit_interleave_encoder.sv
// top level of the z-order (morton) encoder with its register port
//
// Coordinates are taken one per cycle whenever busy is low; the loader
// scatters each into its interleaved bit positions as it arrives, for a
// vector of d coordinates (d from dim_count, 0 read as 1, clamped to
// MAX_DIMS). The finished code goes into a two-entry queue, and the
// emitter puts its d words out on consecutive cycles, word_valid high for
// each and last_word high on the final one; the code is registered in the
// queue and each word again in the emitter's output register. Results are
// not held: the receiver must take each word in its cycle. The emitter's
// one word per cycle sets the sustained rate; busy rises only while two
// finished codes wait in the queue. Writing dim_count drops a partly
// loaded vector.
module zorder_bit_interleave_encoder #(
  parameter int MAX_DIMS   = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [zbie_pkg::WORD_BITS-1:0]    coordinate,
  output logic                              word_valid,
  output logic [zbie_pkg::WORD_BITS-1:0]    code_word,
  output logic                              last_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [zbie_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [zbie_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [zbie_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int NUM_WORDS = (MAX_DIMS < zbie_pkg::DIM_LIMIT) ? MAX_DIMS
                                                              : zbie_pkg::DIM_LIMIT;
  localparam int CODE_W    = zbie_pkg::WORD_BITS * NUM_WORDS;
  localparam int ENTRY_W   = CODE_W + zbie_pkg::DIM_W;

  zbie_pkg::dims_t                    dim_count;
  zbie_pkg::dims_t                    dims;
  logic [zbie_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                               reg_wr;
  logic                               dim_wr;
  logic                               load;
  logic                               push;
  logic                               pop;
  logic [CODE_W-1:0]                  code;
  logic [ENTRY_W-1:0]                 head;
  zbie_pkg::fifo_status_t             status;

  // register port decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[zbie_pkg::APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign dim_wr  = reg_wr && (reg_idx == zbie_pkg::REG_DIM_COUNT);

  always_comb begin
    case (reg_idx)
      zbie_pkg::REG_DIM_COUNT: prdata = zbie_pkg::APB_DATA_W'(dim_count);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= zbie_pkg::DIM_RESET;
    end else if (dim_wr) begin
      dim_count <= pwdata[zbie_pkg::DIM_W-1:0];
    end
  end

  // effective vector length
  always_comb begin
    if (dim_count == '0) begin
      dims = zbie_pkg::DIM_MIN;
    end else if (dim_count > zbie_pkg::DIM_W'(NUM_WORDS)) begin
      dims = zbie_pkg::DIM_W'(NUM_WORDS);
    end else begin
      dims = dim_count;
    end
  end

  // input transfer
  assign busy = status.full;
  assign load = start && !busy;

  zbie_front #(
    .NUM_WORDS  (NUM_WORDS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .coordinate (coordinate),
    .dims       (dims),
    .clear      (dim_wr),
    .push       (push),
    .code       (code)
  );

  zbie_queue #(
    .WIDTH   (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({dims, code}),
    .pop     (pop),
    .head    (head),
    .status  (status)
  );

  zbie_back #(
    .NUM_WORDS  (NUM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .status     (status),
    .pop        (pop),
    .word_valid (word_valid),
    .code_word  (code_word),
    .last_word  (last_word)
  );

endmodule

FILE: sv/zbie_checker.sv
// port-level checks of the z-order encoder and their binding
`include "zorder_bit_interleave_encoder_defines.svh"

module zbie_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            word_valid,
  input logic                            last_word,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic                            pready,
  input logic [zbie_pkg::APB_ADDR_W-1:0] paddr,
  input logic [zbie_pkg::APB_DATA_W-1:0] pwdata,
  input logic [zbie_pkg::APB_DATA_W-1:0] prdata
);

  // register port never waits
  `ZBIE_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

  // last flag only on a result transfer
  `ZBIE_ASSERT_NOW(a_last_with_valid, last_word, word_valid, "last_word without word_valid")

  // words of one vector leave on consecutive cycles
  `ZBIE_ASSERT_NEXT(a_words_contiguous, word_valid && !last_word, word_valid, "gap inside a vector")

  // dim_count reads back what was written
  `ZBIE_ASSERT_NEXT(a_dim_readback, psel && penable && pwrite && pready && (paddr[zbie_pkg::APB_ADDR_W-1:2] == zbie_pkg::REG_DIM_COUNT), (paddr[zbie_pkg::APB_ADDR_W-1:2] != zbie_pkg::REG_DIM_COUNT) || (prdata[zbie_pkg::DIM_W-1:0] == $past(pwdata[zbie_pkg::DIM_W-1:0])), "dim_count readback mismatch")

endmodule

bind zorder_bit_interleave_encoder zbie_checker u_checker (.*);
